>>> design/u2l_pkg.sv
// shared types, constants and tables of the utf-8 to latin-1 filter
`default_nettype none

package u2l_pkg;

  // automaton states and table size
  localparam logic [6:0] ACCEPT_ST = 7'd0;
  localparam logic [6:0] REJECT_ST = 7'd12;
  localparam logic [6:0] MAX_ST    = 7'd96;
  localparam logic [6:0] NST_DEPTH = 7'd108;

  // default depth of the queue between classifier and decoder
  localparam int QUEUE_DEPTH = 4;

  // classified input item
  typedef struct packed {
    logic [3:0] cls;
    logic [7:0] data;
    logic       last;
  } item_t;

  // one result item
  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_byte;
    logic       string_ok;
    logic       done_res;
  } res_t;

  // next state, indexed by state plus byte class
  localparam logic [6:0] NEXT_ST [108] = '{
    7'd0,  7'd12, 7'd24, 7'd36, 7'd60, 7'd96, 7'd84, 7'd12, 7'd12, 7'd12, 7'd48, 7'd72,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd0,  7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd0,  7'd12, 7'd0,  7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12
  };

  // utf-8 byte class
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    unique case (b) inside
      [8'h00:8'h7F]: c = 4'd0;
      [8'h80:8'h8F]: c = 4'd1;
      [8'h90:8'h9F]: c = 4'd9;
      [8'hA0:8'hBF]: c = 4'd7;
      8'hC0, 8'hC1:  c = 4'd8;
      [8'hC2:8'hDF]: c = 4'd2;
      8'hE0:         c = 4'd10;
      [8'hE1:8'hEC]: c = 4'd3;
      8'hED:         c = 4'd4;
      8'hEE, 8'hEF:  c = 4'd3;
      8'hF0:         c = 4'd11;
      [8'hF1:8'hF3]: c = 4'd6;
      8'hF4:         c = 4'd5;
      default:       c = 4'd8;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/u2l_front.sv
// front end: classifies each incoming byte
`default_nettype none

module u2l_front (
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output u2l_pkg::item_t     item
);

  // class lookup and packing
  always_comb begin
    item.cls  = u2l_pkg::byte_class(in_byte);
    item.data = in_byte;
    item.last = in_last;
  end

endmodule

`default_nettype wire

>>> design/u2l_queue.sv
// short queue of classified items between front and back end
`default_nettype none

module u2l_queue #(
  parameter int DEPTH = u2l_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire u2l_pkg::item_t wr_item,
  output logic                full,
  input  wire logic           rd_en,
  output u2l_pkg::item_t      rd_item,
  output logic                empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  u2l_pkg::item_t  ent_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = ent_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/u2l_back.sv
// back end: utf-8 automaton, latin-1 filter and two-entry result buffer
`default_nettype none

module u2l_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u2l_pkg::item_t item,
  input  wire logic           item_avail,
  output logic                item_take,
  input  wire logic           res_pop,
  output logic                res_empty,
  output u2l_pkg::res_t       res
);

  logic [6:0]     st_r, st_eff, st_nxt;
  logic [20:0]    accum_r, cp;
  logic           bad_r, bad_nxt;
  logic [6:0]     idx;
  logic [7:0]     lead_bits;
  logic           emit;
  u2l_pkg::res_t  res_nxt;

  u2l_pkg::res_t  buf_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_pop;

  assign res_empty = (cnt_r == 2'd0);
  assign do_pop    = res_pop && !res_empty;
  assign item_take = item_avail && ((cnt_r != 2'd2) || do_pop);
  assign res       = buf_r[rd_ptr_r];

  // one automaton step
  always_comb begin
    st_eff    = (st_r > u2l_pkg::MAX_ST) ? u2l_pkg::REJECT_ST : st_r;
    lead_bits = (8'hFF >> item.cls) & item.data;
    if (st_eff != u2l_pkg::ACCEPT_ST) begin
      cp = {accum_r[14:0], item.data[5:0]};
    end else begin
      cp = {13'd0, lead_bits};
    end
    idx    = st_eff + {3'd0, item.cls};
    st_nxt = (idx < u2l_pkg::NST_DEPTH) ? u2l_pkg::NEXT_ST[idx] : u2l_pkg::REJECT_ST;

    emit    = 1'b0;
    bad_nxt = bad_r;
    if (st_nxt == u2l_pkg::REJECT_ST) begin
      bad_nxt = 1'b1;
    end else if (st_nxt == u2l_pkg::ACCEPT_ST) begin
      if ((cp < 21'h80) || ((cp >= 21'hA0) && (cp <= 21'hFF))) begin
        emit = 1'b1;
      end else begin
        bad_nxt = 1'b1;
      end
    end

    res_nxt.char_valid = emit;
    res_nxt.char_byte  = emit ? cp[7:0] : 8'd0;
    res_nxt.string_ok  = !bad_nxt && !(item.last && (st_nxt != u2l_pkg::ACCEPT_ST));
    res_nxt.done_res   = item.last;
  end

  // decoder state, cleared after the last byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= u2l_pkg::ACCEPT_ST;
      accum_r <= '0;
      bad_r   <= 1'b0;
    end else if (item_take) begin
      if (item.last) begin
        st_r    <= u2l_pkg::ACCEPT_ST;
        accum_r <= '0;
        bad_r   <= 1'b0;
      end else begin
        st_r    <= st_nxt;
        accum_r <= cp;
        bad_r   <= bad_nxt;
      end
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (item_take) begin
      buf_r[wr_ptr_r] <= res_nxt;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (item_take) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (item_take && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !item_take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/utf8_to_latin1_filter_unit.sv
// top level of the utf-8 to latin-1 filter
`default_nettype none

// Streams a UTF-8 string in one byte per transfer (in_last marks the final byte)
// and returns exactly one result per byte: an ISO-8859-1 character when a code
// point below 0x80 or in 0xA0..0xFF completes, plus a running well-formedness
// verdict that is final on the result flagged out_done_res. Sustained rate is one
// byte per clock while results are popped (a full queue stalls the input); the
// decoder makes one table step per byte. A transferred byte is registered in the
// classifier queue (QDEPTH entries), and the decoder step then writes its result
// into a two-entry result buffer that drives the output. The decoder and verdict
// clear after each last byte.
module utf8_to_latin1_filter_unit #(
  parameter int QDEPTH = u2l_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_char_valid,
  output logic [7:0]      out_char_byte,
  output logic            out_string_ok,
  output logic            out_done_res
);

  u2l_pkg::item_t  cls_item, q_item;
  u2l_pkg::res_t   res;
  logic            q_empty, q_take;

  // classifier
  u2l_front u_front (
    .in_byte (in_byte),
    .in_last (in_last),
    .item    (cls_item)
  );

  // decoupling queue
  u2l_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (cls_item),
    .full    (full),
    .rd_en   (q_take),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // decoder and result buffer
  u2l_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_avail (!q_empty),
    .item_take  (q_take),
    .res_pop    (pop),
    .res_empty  (empty),
    .res        (res)
  );

  assign out_char_valid = res.char_valid;
  assign out_char_byte  = res.char_byte;
  assign out_string_ok  = res.string_ok;
  assign out_done_res   = res.done_res;

  // both sides come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // a dropped character carries a zero byte
  a_zero_when_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_char_valid) |-> (out_char_byte == 8'd0))
    else $error("nonzero byte on a result without a character");

  // c1 control codes are never emitted
  a_no_c1: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_char_valid) |-> (out_char_byte[7:5] != 3'b100))
    else $error("emitted byte in 0x80..0x9f");

endmodule

`default_nettype wire

>>> test/u2l_result_checker.sv
// result checker for the utf-8 to latin-1 filter: predicts each result and compares it
`timescale 1ns / 100ps

module u2l_result_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic       out_char_valid,
  input  wire logic [7:0] out_char_byte,
  input  wire logic       out_string_ok,
  input  wire logic       out_done_res,
  output int              fail_count,
  output int              pending
);

  // decoder states between accept and reject
  localparam logic [6:0] ST_NEED1 = 7'd24;  // one continuation byte left
  localparam logic [6:0] ST_NEED2 = 7'd36;  // two continuation bytes left
  localparam logic [6:0] ST_E0    = 7'd48;  // after e0, needs a0..bf
  localparam logic [6:0] ST_ED    = 7'd60;  // after ed, needs 80..9f
  localparam logic [6:0] ST_F0    = 7'd72;  // after f0, needs 90..bf
  localparam logic [6:0] ST_F1F3  = 7'd84;  // after f1..f3
  localparam logic [6:0] ST_F4    = 7'd96;  // after f4, needs 80..8f

  // byte classes
  localparam logic [3:0] CL_ASCII   = 4'd0;
  localparam logic [3:0] CL_CONT_LO = 4'd1;   // 80..8f
  localparam logic [3:0] CL_LEAD2   = 4'd2;
  localparam logic [3:0] CL_LEAD3   = 4'd3;
  localparam logic [3:0] CL_ED      = 4'd4;
  localparam logic [3:0] CL_F4      = 4'd5;
  localparam logic [3:0] CL_F1F3    = 4'd6;
  localparam logic [3:0] CL_CONT_HI = 4'd7;   // a0..bf
  localparam logic [3:0] CL_INVALID = 4'd8;
  localparam logic [3:0] CL_CONT_MD = 4'd9;   // 90..9f
  localparam logic [3:0] CL_E0      = 4'd10;
  localparam logic [3:0] CL_F0      = 4'd11;

  u2l_pkg::res_t expected_chars [$];
  logic [6:0]    dec_state;
  logic [20:0]   code_point;
  logic          seen_bad;
  int            mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [3:0] class_of(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = CL_ASCII;
    else if (b < 8'h90)  c = CL_CONT_LO;
    else if (b < 8'hA0)  c = CL_CONT_MD;
    else if (b < 8'hC0)  c = CL_CONT_HI;
    else if (b < 8'hC2)  c = CL_INVALID;
    else if (b < 8'hE0)  c = CL_LEAD2;
    else if (b == 8'hE0) c = CL_E0;
    else if (b == 8'hED) c = CL_ED;
    else if (b < 8'hF0)  c = CL_LEAD3;
    else if (b == 8'hF0) c = CL_F0;
    else if (b < 8'hF4)  c = CL_F1F3;
    else if (b == 8'hF4) c = CL_F4;
    else                 c = CL_INVALID;
    return c;
  endfunction

  function automatic logic [6:0] next_state_of(input logic [6:0] st, input logic [3:0] cl);
    logic       lo, md, hi;
    logic [6:0] nxt;
    lo = (cl == CL_CONT_LO);
    md = (cl == CL_CONT_MD);
    hi = (cl == CL_CONT_HI);
    case (st)
      u2l_pkg::ACCEPT_ST: begin
        case (cl)
          CL_ASCII: nxt = u2l_pkg::ACCEPT_ST;
          CL_LEAD2: nxt = ST_NEED1;
          CL_LEAD3: nxt = ST_NEED2;
          CL_E0:    nxt = ST_E0;
          CL_ED:    nxt = ST_ED;
          CL_F0:    nxt = ST_F0;
          CL_F1F3:  nxt = ST_F1F3;
          CL_F4:    nxt = ST_F4;
          default:  nxt = u2l_pkg::REJECT_ST;
        endcase
      end
      ST_NEED1: nxt = (lo | md | hi) ? u2l_pkg::ACCEPT_ST : u2l_pkg::REJECT_ST;
      ST_NEED2: nxt = (lo | md | hi) ? ST_NEED1 : u2l_pkg::REJECT_ST;
      ST_E0:    nxt = hi ? ST_NEED1 : u2l_pkg::REJECT_ST;
      ST_ED:    nxt = (lo | md) ? ST_NEED1 : u2l_pkg::REJECT_ST;
      ST_F0:    nxt = (md | hi) ? ST_NEED2 : u2l_pkg::REJECT_ST;
      ST_F1F3:  nxt = (lo | md | hi) ? ST_NEED2 : u2l_pkg::REJECT_ST;
      ST_F4:    nxt = lo ? ST_NEED2 : u2l_pkg::REJECT_ST;
      default:  nxt = u2l_pkg::REJECT_ST;
    endcase
    return nxt;
  endfunction

  // one decoder step: updates the string state and returns the result for this byte
  function automatic u2l_pkg::res_t decode_byte(input logic [7:0] b, input logic lst);
    u2l_pkg::res_t r;
    logic [3:0]    cl;
    logic [20:0]   cp;
    logic [6:0]    nxt;
    cl = class_of(b);
    if (dec_state != u2l_pkg::ACCEPT_ST) cp = {15'd0, b[5:0]} | (code_point << 6);
    else                                 cp = {13'd0, (8'hFF >> cl) & b};
    nxt = next_state_of(dec_state, cl);
    r = '0;
    if (nxt == u2l_pkg::REJECT_ST) begin
      seen_bad = 1'b1;
    end else if (nxt == u2l_pkg::ACCEPT_ST) begin
      if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
        r.char_valid = 1'b1;
        r.char_byte  = cp[7:0];
      end else begin
        seen_bad = 1'b1;
      end
    end
    dec_state   = nxt;
    code_point  = cp;
    r.string_ok = !seen_bad && !(lst && nxt != u2l_pkg::ACCEPT_ST);
    r.done_res  = lst;
    // string over: back to reset values
    if (lst) begin
      dec_state  = u2l_pkg::ACCEPT_ST;
      code_point = '0;
      seen_bad   = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    u2l_pkg::res_t want;
    if (!rst_n) begin
      expected_chars.delete();
      dec_state  = u2l_pkg::ACCEPT_ST;
      code_point = '0;
      seen_bad   = 1'b0;
    end else begin
      // result transfer
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, %s valid=%0b byte=%h ok=%0b done=%0b",
                   $time, "actual", out_char_valid, out_char_byte, out_string_ok,
                   out_done_res);
        end else begin
          want = expected_chars.pop_front();
          check_field("char_valid", int'(want.char_valid), int'(out_char_valid));
          check_field("char_byte", int'(want.char_byte), int'(out_char_byte));
          check_field("string_ok", int'(want.string_ok), int'(out_string_ok));
          check_field("done_res", int'(want.done_res), int'(out_done_res));
        end
      end
      // input transfer
      if (push && !full) expected_chars = {expected_chars, decode_byte(in_byte, in_last)};
    end
    pending <= expected_chars.size();
  end

endmodule

>>> test/tb_utf8_to_latin1_filter_unit.sv
// testbench top for the utf-8 to latin-1 filter: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_utf8_to_latin1_filter_unit;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 80;
  localparam int BURST_BYTES  = 30;
  localparam int RANDOM_BYTES = 440;

  // kinds of code point for random strings
  localparam int KIND_ASCII    = 0;
  localparam int KIND_LATIN_HI = 1;  // a0..ff
  localparam int KIND_C1       = 2;  // 80..9f, not convertible
  localparam int KIND_WIDE2    = 3;  // 100..7ff
  localparam int KIND_WIDE3    = 4;
  localparam int KIND_WIDE4    = 5;

  // directed bytes, {last, byte}
  localparam logic [8:0] DIRECTED_SEQ [26] = '{
    9'h100,                          // nul alone
    9'h07F, 9'h0C2, 9'h0A0, 9'h0C3, 9'h1BF,  // ascii max, a0 and ff
    9'h0C2, 9'h180,                  // c1 control code point
    9'h080, 9'h141,                  // stray continuation, then reject sink
    9'h0E0, 9'h1A0,                  // truncated sequence at end
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // highest code point
    9'h1FF,                          // never valid
    9'h0ED, 9'h1A0,                  // surrogate
    9'h0E1, 9'h080, 9'h180,          // three bytes, too wide
    9'h0F0, 9'h090, 9'h080, 9'h180   // four bytes, too wide
  };

  logic       clk     = 1'b0;
  logic       rst_n   = 1'b0;
  logic       push    = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       pop     = 1'b0;
  logic       full, empty;
  logic       out_char_valid, out_string_ok, out_done_res;
  logic [7:0] out_char_byte;
  int         fail_count, pending;
  int         cycles = 0;
  int         bytes_sent = 0;
  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;
  logic       rx_hold  = 1'b0;
  logic [7:0] str_bytes [$];

  always #2 clk = ~clk;

  utf8_to_latin1_filter_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .empty          (empty),
    .pop            (pop),
    .out_char_valid (out_char_valid),
    .out_char_byte  (out_char_byte),
    .out_string_ok  (out_string_ok),
    .out_done_res   (out_done_res)
  );

  u2l_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .empty          (empty),
    .pop            (pop),
    .out_char_valid (out_char_valid),
    .out_char_byte  (out_char_byte),
    .out_string_ok  (out_string_ok),
    .out_done_res   (out_done_res),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[utf8_to_latin1_filter_unit] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // utf-8 encoding of a random code point, optionally cut short
  task automatic add_code_point(input int kind, input bit cut);
    logic [20:0] cp;
    logic [7:0]  seq [$];
    int          keep;
    case (kind)
      KIND_ASCII:    cp = 21'($urandom_range(0, 'h7F));
      KIND_LATIN_HI: cp = 21'($urandom_range('hA0, 'hFF));
      KIND_C1:       cp = 21'($urandom_range('h80, 'h9F));
      KIND_WIDE2:    cp = 21'($urandom_range('h100, 'h7FF));
      KIND_WIDE3: begin
        if ($urandom_range(0, 1) == 0) cp = 21'($urandom_range('h800, 'hD7FF));
        else                           cp = 21'($urandom_range('hE000, 'hFFFF));
      end
      default:       cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    if (cp < 21'h80) begin
      seq = {seq, cp[7:0]};
    end else if (cp < 21'h800) begin
      seq = {seq, {3'b110, cp[10:6]}};
      seq = {seq, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      seq = {seq, {4'b1110, cp[15:12]}};
      seq = {seq, {2'b10, cp[11:6]}};
      seq = {seq, {2'b10, cp[5:0]}};
    end else begin
      seq = {seq, {5'b11110, cp[20:18]}};
      seq = {seq, {2'b10, cp[17:12]}};
      seq = {seq, {2'b10, cp[11:6]}};
      seq = {seq, {2'b10, cp[5:0]}};
    end
    keep = (cut && seq.size() > 1) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < keep; i++) str_bytes = {str_bytes, seq[i]};
  endtask

  // mostly well-formed strings, some broken sequences and noise
  task automatic build_string();
    int pieces, r;
    str_bytes.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      if (r < 40)      add_code_point(KIND_ASCII, 1'b0);
      else if (r < 62) add_code_point(KIND_LATIN_HI, 1'b0);
      else if (r < 69) add_code_point(KIND_C1, 1'b0);
      else if (r < 76) add_code_point(KIND_WIDE2, 1'b0);
      else if (r < 82) add_code_point(KIND_WIDE3, 1'b0);
      else if (r < 86) add_code_point(KIND_WIDE4, 1'b0);
      else if (r < 93) add_code_point($urandom_range(KIND_LATIN_HI, KIND_WIDE4), 1'b1);
      else             str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
    end
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      gap = rx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  // input side and verdict
  initial begin
    int burst_start, random_start;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner strings
    foreach (DIRECTED_SEQ[i]) send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);

    // pause until every result is back
    push <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);

    // back-to-back burst against a stalled result side
    rx_hold     = 1'b1;
    tx_quiet    = 1'b1;
    burst_start = bytes_sent;
    while (bytes_sent - burst_start < BURST_BYTES) begin
      build_string();
      send_string();
    end
    tx_quiet = 1'b0;

    // random strings, some stretches without idling
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_string();
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      send_string();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // drain
    push <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[utf8_to_latin1_filter_unit] OK");
    end else begin
      $display("[utf8_to_latin1_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
